### rtl/chm_pkg.sv
package chm_pkg;

	localparam int POOL_ENTRIES = 2048;
	localparam int BUCKET_COUNT = 4096;
	localparam int EPOCH_BITS   = 16;

	localparam int NODE_W = $clog2(POOL_ENTRIES);
	localparam int BKT_W  = $clog2(BUCKET_COUNT);
	localparam int STEP_W = NODE_W + 1;

	localparam logic [63:0] HM_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] HM_MUL1   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] HM_MUL2   = 64'h94d049bb133111eb;

	localparam logic [2:0] ACT_ACCESS   = 3'd0;
	localparam logic [2:0] ACT_WRITE    = 3'd1;
	localparam logic [2:0] ACT_CONTAINS = 3'd2;
	localparam logic [2:0] ACT_ERASE    = 3'd3;
	localparam logic [2:0] ACT_CLEAR    = 3'd4;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_MISS     = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [1:0] RV_ZERO = 2'd0;
	localparam logic [1:0] RV_RAM  = 2'd1;
	localparam logic [1:0] RV_WV   = 2'd2;

	localparam logic [2:0] HOP_NONE = 3'd0;
	localparam logic [2:0] HOP_ADD  = 3'd1;
	localparam logic [2:0] HOP_P0   = 3'd2;
	localparam logic [2:0] HOP_P1   = 3'd3;
	localparam logic [2:0] HOP_P2   = 3'd4;
	localparam logic [2:0] HOP_FIN  = 3'd5;

	typedef struct packed {
		logic       latch;
		logic [2:0] hop;
		logic       hround;
		logic       head_chk;
		logic       advance;
		logic       rd_free;
		logic       take_free;
		logic       take_top;
		logic       ins;
		logic       ins_wv;
		logic       wr_found;
		logic       unlink;
		logic       recycle;
		logic       do_clear;
		logic       clr_start;
		logic       clr_step;
		logic       fin;
		logic [1:0] fin_status;
		logic [1:0] rv_sel;
	} chm_cmd_t;

	typedef struct packed {
		logic walk_end;
		logic key_hit;
		logic free_avail;
		logic pool_full;
		logic epoch_wrap;
		logic clr_last;
	} chm_stat_t;

endpackage

### rtl/chm_ram.sv
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/chm_ctrl.sv
module chm_ctrl import chm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [2:0] action,
	input  chm_stat_t stat,
	output chm_cmd_t  cmd,
	output logic      busy
);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_HADD  = 5'd2;
	localparam logic [4:0] S_M1A   = 5'd3;
	localparam logic [4:0] S_M1B   = 5'd4;
	localparam logic [4:0] S_M1C   = 5'd5;
	localparam logic [4:0] S_M2A   = 5'd6;
	localparam logic [4:0] S_M2B   = 5'd7;
	localparam logic [4:0] S_M2C   = 5'd8;
	localparam logic [4:0] S_HFIN  = 5'd9;
	localparam logic [4:0] S_RDB   = 5'd10;
	localparam logic [4:0] S_HCHK  = 5'd11;
	localparam logic [4:0] S_WRD   = 5'd12;
	localparam logic [4:0] S_WCMP  = 5'd13;
	localparam logic [4:0] S_ALRD  = 5'd14;
	localparam logic [4:0] S_ALGET = 5'd15;
	localparam logic [4:0] S_INS   = 5'd16;
	localparam logic [4:0] S_ER1   = 5'd17;
	localparam logic [4:0] S_ER2   = 5'd18;

	logic [4:0] state_q, state_d;
	logic [2:0] act_q;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			act_q   <= ACT_ACCESS;
		end else begin
			state_q <= state_d;
			if (cmd.latch) begin
				act_q <= action;
			end
		end
	end

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					if (action == ACT_CLEAR) begin
						cmd.do_clear   = 1'b1;
						cmd.fin        = 1'b1;
						cmd.fin_status = ST_FOUND;
						cmd.rv_sel     = RV_ZERO;
						if (stat.epoch_wrap) begin
							cmd.clr_start = 1'b1;
							state_d       = S_CLR;
						end
					end else if (action > ACT_CLEAR) begin
						cmd.fin        = 1'b1;
						cmd.fin_status = ST_MISS;
						cmd.rv_sel     = RV_ZERO;
					end else begin
						state_d = S_HADD;
					end
				end
			end
			S_HADD: begin
				cmd.hop = HOP_ADD;
				state_d = S_M1A;
			end
			S_M1A: begin
				cmd.hop = HOP_P0;
				state_d = S_M1B;
			end
			S_M1B: begin
				cmd.hop = HOP_P1;
				state_d = S_M1C;
			end
			S_M1C: begin
				cmd.hop = HOP_P2;
				state_d = S_M2A;
			end
			S_M2A: begin
				cmd.hop    = HOP_P0;
				cmd.hround = 1'b1;
				state_d    = S_M2B;
			end
			S_M2B: begin
				cmd.hop    = HOP_P1;
				cmd.hround = 1'b1;
				state_d    = S_M2C;
			end
			S_M2C: begin
				cmd.hop    = HOP_P2;
				cmd.hround = 1'b1;
				state_d    = S_HFIN;
			end
			S_HFIN: begin
				cmd.hop = HOP_FIN;
				state_d = S_RDB;
			end
			S_RDB: begin
				state_d = S_HCHK;
			end
			S_HCHK: begin
				cmd.head_chk = 1'b1;
				state_d      = S_WRD;
			end
			S_WRD: begin
				if (stat.walk_end) begin
					if (act_q == ACT_ACCESS || act_q == ACT_WRITE) begin
						if (stat.free_avail) begin
							state_d = S_ALRD;
						end else if (stat.pool_full) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = ST_FULL;
							cmd.rv_sel     = RV_ZERO;
							state_d        = S_IDLE;
						end else begin
							cmd.take_top = 1'b1;
							state_d      = S_INS;
						end
					end else begin
						cmd.fin        = 1'b1;
						cmd.fin_status = ST_MISS;
						cmd.rv_sel     = RV_ZERO;
						state_d        = S_IDLE;
					end
				end else begin
					state_d = S_WCMP;
				end
			end
			S_WCMP: begin
				if (stat.key_hit) begin
					if (act_q == ACT_ERASE) begin
						state_d = S_ER1;
					end else begin
						cmd.fin        = 1'b1;
						cmd.fin_status = ST_FOUND;
						if (act_q == ACT_ACCESS) begin
							cmd.rv_sel = RV_RAM;
						end else if (act_q == ACT_WRITE) begin
							cmd.wr_found = 1'b1;
							cmd.rv_sel   = RV_WV;
						end else begin
							cmd.rv_sel = RV_ZERO;
						end
						state_d = S_IDLE;
					end
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_WRD;
				end
			end
			S_ALRD: begin
				cmd.rd_free = 1'b1;
				state_d     = S_ALGET;
			end
			S_ALGET: begin
				cmd.take_free = 1'b1;
				state_d       = S_INS;
			end
			S_INS: begin
				cmd.ins        = 1'b1;
				cmd.ins_wv     = (act_q == ACT_WRITE);
				cmd.fin        = 1'b1;
				cmd.fin_status = ST_INSERTED;
				cmd.rv_sel     = (act_q == ACT_WRITE) ? RV_WV : RV_ZERO;
				state_d        = S_IDLE;
			end
			S_ER1: begin
				cmd.unlink = 1'b1;
				state_d    = S_ER2;
			end
			S_ER2: begin
				cmd.recycle    = 1'b1;
				cmd.fin        = 1'b1;
				cmd.fin_status = ST_FOUND;
				cmd.rv_sel     = RV_ZERO;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_fin_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (state_q == S_IDLE || state_q == S_CLR))
		else $error("transaction finished without returning to idle");

	a_lookup_hashes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && action <= ACT_ERASE) |=> (state_q == S_HADD))
		else $error("lookup transaction did not start hashing");

endmodule

### rtl/chm_datapath.sv
module chm_datapath import chm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  chm_cmd_t           cmd,
	input  logic [63:0]        seed,
	input  logic [63:0]        key,
	input  logic [31:0]        write_value,
	output chm_stat_t          stat,
	output logic               done,
	output logic [1:0]         status,
	output logic [31:0]        read_value,
	output logic [NODE_W-1:0]  live_count
);

	logic [63:0]       key_q, x_q, acc_q;
	logic [31:0]       wv_q;
	logic [BKT_W-1:0]  bucket_q, clr_q;
	logic [NODE_W-1:0] head_q, cur_q, prev_q, new_q, free_q, pool_q, count_q;
	logic [STEP_W-1:0] steps_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [31:0]       rv_q;

	logic [63:0] y, m, fin_x, prod;
	logic [31:0] mul_a, mul_b;

	logic [63:0]           key_rd;
	logic [31:0]           val_rd;
	logic [NODE_W-1:0]     nx_rd, head_rd;
	logic [EPOCH_BITS-1:0] ep_rd;

	logic                  key_we, val_we, nx_we, head_we, ep_we;
	logic [NODE_W-1:0]     val_wa, nx_wa, nx_ra;
	logic [31:0]           val_wd;
	logic [NODE_W-1:0]     nx_wd, head_wd;
	logic [BKT_W-1:0]      ep_wa;
	logic [EPOCH_BITS-1:0] ep_wd;

	assign y     = cmd.hround ? (x_q ^ (x_q >> 27)) : (x_q ^ (x_q >> 30));
	assign m     = cmd.hround ? HM_MUL2 : HM_MUL1;
	assign mul_a = (cmd.hop == HOP_P2) ? y[63:32] : y[31:0];
	assign mul_b = (cmd.hop == HOP_P1) ? m[63:32] : m[31:0];
	assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
	assign fin_x = x_q ^ (x_q >> 31);

	assign stat.walk_end   = (cur_q == '0) || steps_q[STEP_W-1];
	assign stat.key_hit    = (key_rd == key_q);
	assign stat.free_avail = (free_q != '0);
	assign stat.pool_full  = (pool_q == NODE_W'(POOL_ENTRIES - 1));
	assign stat.epoch_wrap = (epoch_q == '1);
	assign stat.clr_last   = (clr_q == BKT_W'(BUCKET_COUNT - 1));

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = rv_q;
	assign live_count = count_q;

	assign nx_ra = cmd.rd_free ? free_q : cur_q;

	always_comb begin
		key_we  = cmd.ins;
		val_we  = cmd.ins || cmd.wr_found;
		val_wa  = cmd.ins ? new_q : cur_q;
		val_wd  = (cmd.wr_found || cmd.ins_wv) ? wv_q : 32'd0;
		nx_we   = cmd.ins || cmd.recycle || (cmd.unlink && prev_q != '0);
		nx_wa   = cur_q;
		nx_wd   = free_q;
		if (cmd.ins) begin
			nx_wa = new_q;
			nx_wd = head_q;
		end else if (cmd.unlink) begin
			nx_wa = prev_q;
			nx_wd = nx_rd;
		end
		head_we = cmd.ins || (cmd.unlink && prev_q == '0);
		head_wd = cmd.ins ? new_q : nx_rd;
		ep_we   = cmd.ins || cmd.clr_step;
		ep_wa   = cmd.clr_step ? clr_q : bucket_q;
		ep_wd   = cmd.clr_step ? '0 : epoch_q;
	end

	chm_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(new_q), .wdata(key_q),
		.raddr(cur_q), .rdata(key_rd)
	);

	chm_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_val_ram (
		.clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
		.raddr(cur_q), .rdata(val_rd)
	);

	chm_ram #(.WIDTH(NODE_W), .DEPTH(POOL_ENTRIES)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.raddr(nx_ra), .rdata(nx_rd)
	);

	chm_ram #(.WIDTH(NODE_W), .DEPTH(BUCKET_COUNT)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(bucket_q), .wdata(head_wd),
		.raddr(bucket_q), .rdata(head_rd)
	);

	chm_ram #(.WIDTH(EPOCH_BITS), .DEPTH(BUCKET_COUNT)) u_epoch_ram (
		.clk(clk), .we(ep_we), .waddr(ep_wa), .wdata(ep_wd),
		.raddr(bucket_q), .rdata(ep_rd)
	);

	// Hash datapath: each 64-bit product is built from three 32x32 partials.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			key_q <= key;
			wv_q  <= write_value;
		end
		case (cmd.hop)
			HOP_ADD: x_q <= key_q + seed + HM_GOLDEN;
			HOP_P0:  acc_q <= prod;
			HOP_P1:  acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			HOP_P2:  x_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
			HOP_FIN: bucket_q <= fin_x[BKT_W-1:0];
			default: begin
			end
		endcase
		if (cmd.head_chk) begin
			head_q <= (ep_rd == epoch_q) ? head_rd : '0;
		end
		if (cmd.take_free) begin
			new_q <= free_q;
		end else if (cmd.take_top) begin
			new_q <= pool_q + NODE_W'(1);
		end
		if (cmd.fin) begin
			status_q <= cmd.fin_status;
			case (cmd.rv_sel)
				RV_RAM:  rv_q <= val_rd;
				RV_WV:   rv_q <= wv_q;
				default: rv_q <= 32'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			prev_q  <= '0;
			steps_q <= '0;
			free_q  <= '0;
			pool_q  <= '0;
			count_q <= '0;
			epoch_q <= EPOCH_BITS'(1);
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cmd.head_chk) begin
				cur_q   <= (ep_rd == epoch_q) ? head_rd : '0;
				prev_q  <= '0;
				steps_q <= '0;
			end else if (cmd.advance) begin
				prev_q  <= cur_q;
				cur_q   <= nx_rd;
				steps_q <= steps_q + STEP_W'(1);
			end
			if (cmd.do_clear) begin
				epoch_q <= stat.epoch_wrap ? EPOCH_BITS'(1) : epoch_q + EPOCH_BITS'(1);
				pool_q  <= '0;
				free_q  <= '0;
				count_q <= '0;
			end else begin
				if (cmd.take_free) begin
					free_q <= nx_rd;
				end else if (cmd.recycle) begin
					free_q <= cur_q;
				end
				if (cmd.take_top) begin
					pool_q <= pool_q + NODE_W'(1);
				end
				if (cmd.ins) begin
					count_q <= count_q + NODE_W'(1);
				end else if (cmd.recycle && count_q != '0) begin
					count_q <= count_q - NODE_W'(1);
				end
			end
			if (cmd.clr_start) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + BKT_W'(1);
			end
		end
	end

	a_ins_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> (new_q != '0))
		else $error("insert targets the null node");

	a_recycle_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.recycle |-> (cur_q != '0 && $past(cmd.unlink)))
		else $error("recycle without a preceding unlink of a real node");

endmodule

### rtl/chained_hash_map_engine_unit.sv
// Key-value map with separate chaining over a 2048-node pool and 4096 buckets.
// A request is taken when start is high and busy is low; its result appears
// for one cycle with done high, in the cycle after the request finishes, and
// cannot be held off. A lookup first hashes the key (one shared 32x32
// multiplier, three partial products per 64-bit multiply), then reads and
// checks the bucket, then compares chain nodes one at a time (one read of the
// node memories each) until a hit or the end of the chain. An insert then
// takes a node from the top of the pool, or reads and takes a freed node, and
// writes it; an erase unlinks the node and then recycles it. Clear and
// unknown actions put their result out in the cycle right after they are
// taken. After reset, and after a clear that wraps the epoch tag, the block
// is busy while it sweeps the bucket tag memory. hash_seed (the seed register
// at bus address 0) is to be written only while the block is idle; the block
// does not enforce this.
module chained_hash_map_engine_unit import chm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        action,
	input  logic [63:0]       key,
	input  logic [31:0]       write_value,
	output logic              done,
	output logic [1:0]        status,
	output logic [31:0]       read_value,
	output logic [NODE_W-1:0] live_count,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [0:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	logic [63:0] seed_q;
	chm_cmd_t    cmd;
	chm_stat_t   stat;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? seed_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
		end else if (psel && penable && pwrite && pready && paddr == 1'b0) begin
			seed_q <= pwdata;
		end
	end

	chm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	chm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .seed(seed_q), .key(key),
		.write_value(write_value), .stat(stat), .done(done), .status(status),
		.read_value(read_value), .live_count(live_count)
	);

endmodule
